FILE: hw/rtl/slli_pkg.sv
package slli_pkg;

	// fixed field widths
	localparam int ID_W     = 64;
	localparam int ACT_W    = 2;
	localparam int MODE_W   = 2;
	localparam int POS_W    = 6;
	localparam int ST_W     = 3;
	localparam int CAP_W    = 6;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	// parameter defaults
	localparam int DEPTH_DEF       = 64;
	localparam int HANDLE_BITS_DEF = 48;

	// register reset and index
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(63);
	localparam logic             REG_CAPACITY = 1'b0;

	// actions
	localparam logic [ACT_W-1:0] ACT_GET    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_SETLL  = 2'd3;

	// lock modes
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BAD   = 2'd3;

	// result status codes
	localparam logic [ST_W-1:0] ST_EXISTING = 3'd0;
	localparam logic [ST_W-1:0] ST_APPENDED = 3'd1;
	localparam logic [ST_W-1:0] ST_INSERTED = 3'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd4;
	localparam logic [ST_W-1:0] ST_DONE     = 3'd5;

endpackage

FILE: hw/rtl/slli_if.sv
interface slli_req_if #(
	parameter int HANDLE_BITS = 48
);
	import slli_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [ACT_W-1:0]       action;
	logic [ID_W-1:0]        lock_id;
	logic [HANDLE_BITS-1:0] lock_handle;
	logic [MODE_W-1:0]      want_mode;
	logic [POS_W-1:0]       locked_upto;

	modport source (output valid, action, lock_id, lock_handle, want_mode, locked_upto,
		input ready);
	modport sink (input valid, action, lock_id, lock_handle, want_mode, locked_upto,
		output ready);
endinterface

interface slli_rsp_if;
	import slli_pkg::*;

	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  position;
	logic [ST_W-1:0]   status;
	logic [MODE_W-1:0] entry_mode;
	logic [POS_W-1:0]  entry_count;
	logic [POS_W-1:0]  last_locked;

	modport source (output valid, position, status, entry_mode, entry_count, last_locked,
		input ready);
	modport sink (input valid, position, status, entry_mode, entry_count, last_locked,
		output ready);
endinterface

FILE: hw/rtl/sorted_lock_list_insert_top.sv
// Channel  Dir  Handshake              Word
// req      in   valid/ready            action, lock_id, lock_handle, want_mode, locked_upto
// rsp      out  valid/ready            position, status, entry_mode, entry_count, last_locked
// apb      cfg  psel/penable, pready=1 capacity at byte address 0
//
// Clear, set-last-locked and a zero key go straight to the result. Get-or-add and
// search read and compare one entry at a time; a miss then appends, inserts or
// reports not-found or full; an insert first shifts each later entry up by one. The
// sequencer is bound by the single read port of the entry memory, which one compare
// unit walks one entry at a time.
// Reset clears count, last-locked mark and result valid and sets capacity to
// 63; the entry memory is not cleared. A held result stalls only the emit state.
module sorted_lock_list_insert_top #(
	parameter int DEPTH       = slli_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = slli_pkg::HANDLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	slli_req_if.sink                      req,
	slli_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [slli_pkg::APB_AW-1:0]   paddr,
	input  logic [slli_pkg::APB_DW-1:0]   pwdata,
	output logic [slli_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import slli_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int XW = (CW > POS_W) ? CW : POS_W;
	localparam int WW = ID_W + HANDLE_BITS + MODE_W;
	localparam logic [XW-1:0] MAX_POS = XW'(DEPTH - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_MISS  = 3'd3;
	localparam logic [2:0] S_SHRD  = 3'd4;
	localparam logic [2:0] S_SHWR  = 3'd5;
	localparam logic [2:0] S_INS   = 3'd6;
	localparam logic [2:0] S_EMIT  = 3'd7;

	logic [2:0]             state_q;
	logic [CAP_W-1:0]       cap_q;
	logic [AW-1:0]          count_q;
	logic [AW-1:0]          last_q;
	logic [ACT_W-1:0]       act_q;
	logic [ID_W-1:0]        key_q;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic [MODE_W-1:0]      mode_q;
	logic [CW-1:0]          p_q;
	logic [AW-1:0]          s_q;
	logic [CW-1:0]          res_pos_q;
	logic [ST_W-1:0]        res_st_q;
	logic [MODE_W-1:0]      res_mode_q;

	logic                   out_valid_q;
	logic [POS_W-1:0]       out_pos_q;
	logic [ST_W-1:0]        out_st_q;
	logic [MODE_W-1:0]      out_mode_q;
	logic [POS_W-1:0]       out_cnt_q;
	logic [POS_W-1:0]       out_ll_q;

	logic [WW-1:0]          mem [DEPTH];
	logic [WW-1:0]          rd_q;
	logic [AW-1:0]          ra;
	logic                   we;
	logic [AW-1:0]          wa;
	logic [WW-1:0]          wd;

	logic [ID_W-1:0]        rd_id;
	logic [HANDLE_BITS-1:0] rd_hdl;
	logic [MODE_W-1:0]      rd_mode;
	logic [MODE_W-1:0]      up_mode;
	logic [MODE_W-1:0]      in_mode;
	logic [XW-1:0]          usable;
	logic                   full;
	logic                   at_end;
	logic                   accept;
	logic                   emit_go;
	logic [XW-1:0]          upto_x;

	// split the registered read word
	assign rd_id   = rd_q[WW-1 -: ID_W];
	assign rd_hdl  = rd_q[MODE_W +: HANDLE_BITS];
	assign rd_mode = rd_q[MODE_W-1:0];
	assign up_mode = (rd_mode < mode_q) ? mode_q : rd_mode;
	assign in_mode = (req.want_mode == MODE_BAD) ? MODE_WRITE : req.want_mode;

	// usable capacity and table-full test
	assign usable = (XW'(cap_q) > MAX_POS) ? MAX_POS : XW'(cap_q);
	assign full   = XW'(count_q) >= usable;
	assign at_end = p_q > CW'(count_q);
	assign upto_x = XW'(req.locked_upto);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign emit_go   = !out_valid_q || rsp.ready;

	// APB register port
	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1] == REG_CAPACITY) ? APB_DW'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[APB_AW-1] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// memory port control
	always_comb begin
		ra = p_q[AW-1:0];
		we = 1'b0;
		wa = p_q[AW-1:0];
		wd = {key_q, hdl_q, mode_q};
		unique case (state_q)
			S_SHRD: ra = s_q;
			S_CMP: begin
				we = (rd_id == key_q) && (act_q == ACT_GET);
				wd = {rd_id, rd_hdl, up_mode};
			end
			S_MISS: we = (act_q == ACT_GET) && !full && at_end;
			S_SHWR: begin
				we = 1'b1;
				wa = AW'(s_q + 1'b1);
				wd = rd_q;
			end
			S_INS: we = 1'b1;
			default: ;
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	// hold the request fields
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= req.action;
			key_q  <= req.lock_id;
			hdl_q  <= req.lock_handle;
			mode_q <= in_mode;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			last_q     <= '0;
			p_q        <= '0;
			s_q        <= '0;
			res_pos_q  <= '0;
			res_st_q   <= ST_DONE;
			res_mode_q <= MODE_NONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_pos_q  <= '0;
						res_mode_q <= MODE_NONE;
						p_q        <= CW'(1);
						priority if (req.action == ACT_CLEAR) begin
							count_q  <= '0;
							last_q   <= '0;
							res_st_q <= ST_DONE;
							state_q  <= S_EMIT;
						end else if (req.action == ACT_SETLL) begin
							last_q   <= (upto_x > XW'(count_q)) ? count_q : AW'(upto_x);
							res_st_q <= ST_DONE;
							state_q  <= S_EMIT;
						end else if (req.lock_id == '0) begin
							res_st_q <= ST_NOTFOUND;
							state_q  <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					state_q <= at_end ? S_MISS : S_CMP;
				end
				S_CMP: begin
					priority if (rd_id == key_q) begin
						res_pos_q  <= p_q;
						res_st_q   <= ST_EXISTING;
						res_mode_q <= (act_q == ACT_GET) ? up_mode : rd_mode;
						state_q    <= S_EMIT;
					end else if (rd_id > key_q) begin
						state_q <= S_MISS;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_MISS: begin
					priority if (act_q == ACT_SEARCH) begin
						res_st_q <= ST_NOTFOUND;
						state_q  <= S_EMIT;
					end else if (full) begin
						res_st_q <= ST_FULL;
						state_q  <= S_EMIT;
					end else if (at_end) begin
						count_q    <= count_q + 1'b1;
						res_pos_q  <= p_q;
						res_st_q   <= ST_APPENDED;
						res_mode_q <= mode_q;
						state_q    <= S_EMIT;
					end else begin
						s_q     <= count_q;
						state_q <= S_SHRD;
					end
				end
				S_SHRD: begin
					state_q <= S_SHWR;
				end
				S_SHWR: begin
					if (CW'(s_q) == p_q) begin
						state_q <= S_INS;
					end else begin
						s_q     <= s_q - 1'b1;
						state_q <= S_SHRD;
					end
				end
				S_INS: begin
					count_q <= count_q + 1'b1;
					if (CW'(last_q) >= p_q) begin
						last_q <= last_q + 1'b1;
					end
					res_pos_q  <= p_q;
					res_st_q   <= ST_INSERTED;
					res_mode_q <= mode_q;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && emit_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && emit_go) begin
			out_pos_q  <= POS_W'(res_pos_q);
			out_st_q   <= res_st_q;
			out_mode_q <= res_mode_q;
			out_cnt_q  <= POS_W'(count_q);
			out_ll_q   <= POS_W'(last_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.position    = out_pos_q;
	assign rsp.status      = out_st_q;
	assign rsp.entry_mode  = out_mode_q;
	assign rsp.entry_count = out_cnt_q;
	assign rsp.last_locked = out_ll_q;

	// last-locked mark never passes the entry count
	a_last_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		last_q <= count_q)
		else $error("last-locked mark beyond entry count");

	// entry count only steps up by one or drops to zero
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == AW'($past(count_q) + 1'b1)) || (count_q == '0))
		else $error("entry count jumped");

	// a position is reported exactly for found or written entries
	a_pos_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.position != '0) ==
			(rsp.status == ST_EXISTING || rsp.status == ST_APPENDED ||
			rsp.status == ST_INSERTED)))
		else $error("position and status disagree");

	// an accepted word leaves the sequencer busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("sequencer idle after accept");

endmodule
